// ===== src/ntph_pkg.sv =====
// ntph_pkg: shared constants, types and helper functions of the nt password hash block
`default_nettype none
package ntph_pkg;

  // passphrase bound and message byte counter
  localparam int MAX_PASS_BYTES = 512;
  localparam int MSG_MAX        = 2 * MAX_PASS_BYTES;
  localparam int MSG_W          = $clog2(MSG_MAX + 1);

  // md4 schedule
  localparam int ROUNDS = 48;
  localparam int RND_W  = $clog2(ROUNDS);

  localparam logic [1:0] ROUND_F = 2'd0;
  localparam logic [1:0] ROUND_G = 2'd1;
  localparam logic [1:0] ROUND_H = 2'd2;

  localparam logic [31:0] IV_A  = 32'h6745_2301;
  localparam logic [31:0] IV_B  = 32'hefcd_ab89;
  localparam logic [31:0] IV_C  = 32'h98ba_dcfe;
  localparam logic [31:0] IV_D  = 32'h1032_5476;
  localparam logic [31:0] K_G   = 32'h5a82_7999;
  localparam logic [31:0] K_H   = 32'h6ed9_eba1;

  // block buffer layout in 16-bit halves
  localparam logic [4:0]  HALF_LAST = 5'd31;
  localparam logic [4:0]  HALF_LEN  = 5'd28;
  localparam logic [3:0]  WORD_LEN_LO = 4'd14;
  localparam logic [3:0]  WORD_LEN_HI = 4'd15;
  localparam logic [15:0] PAD_HALF  = 16'h0080;

  // result string
  localparam int NUM_CHARS  = 36;
  localparam int LEAD_CHARS = 4;
  localparam int CNT_W      = $clog2(NUM_CHARS);
  localparam logic [6:0] ERR_CHAR = 7'h00;

  typedef struct packed {
    logic start;
    logic reinit;
  } ntph_core_ctl_t;

  // rotate amount for a round group and step within a group of four
  function automatic logic [4:0] md4_shift(input logic [1:0] grp, input logic [1:0] j);
    logic [4:0] s;
    s = 5'd3;
    case (grp)
      ROUND_F: begin
        case (j)
          2'd0: s = 5'd3;
          2'd1: s = 5'd7;
          2'd2: s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      ROUND_G: begin
        case (j)
          2'd0: s = 5'd3;
          2'd1: s = 5'd5;
          2'd2: s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        case (j)
          2'd0: s = 5'd3;
          2'd1: s = 5'd9;
          2'd2: s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
    return s;
  endfunction

  // message word index of a round step
  function automatic logic [3:0] md4_widx(input logic [1:0] grp, input logic [3:0] j);
    logic [3:0] w;
    w = j;
    case (grp)
      ROUND_F: w = j;
      ROUND_G: w = {j[1:0], j[3:2]};
      default: w = {j[0], j[1], j[2], j[3]};
    endcase
    return w;
  endfunction

  // lowercase hex digit
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h57 + {3'b000, nib};
    end
    return c;
  endfunction

  // the "$3$$" lead
  function automatic logic [6:0] lead_char(input logic [1:0] idx);
    logic [6:0] c;
    case (idx)
      2'd1:    c = 7'h33;
      default: c = 7'h24;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/ntph_md4_core.sv =====
// ntph_md4_core: md4 chaining state and one shared round unit stepped through the 48 rounds
`default_nettype none
module ntph_md4_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ntph_pkg::ntph_core_ctl_t ctl_i,
  output logic [3:0]                 w_idx_o,
  input  wire logic [31:0]           w_i,
  output logic                       done_o,
  output logic [127:0]               digest_o
);
  import ntph_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_FOLD  = 3'b100
  } core_state_e;

  core_state_e st_q, st_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] h_q [4];
  logic [1:0]  grp;
  logic [3:0]  stp;
  logic [31:0] f_val, k_val, sum;
  logic [63:0] rot;
  logic [4:0]  sh;

  assign grp = rnd_q[RND_W-1:RND_W-2];
  assign stp = rnd_q[3:0];
  assign w_idx_o = md4_widx(grp, stp);
  assign sh  = md4_shift(grp, stp[1:0]);

  // round function and constant
  always_comb begin
    case (grp)
      ROUND_F: begin
        f_val = (b_q & c_q) | (~b_q & d_q);
        k_val = '0;
      end
      ROUND_G: begin
        f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
        k_val = K_G;
      end
      default: begin
        f_val = b_q ^ c_q ^ d_q;
        k_val = K_H;
      end
    endcase
  end

  assign sum = a_q + f_val + w_i + k_val;
  assign rot = {sum, sum} << sh;

  // sequencer
  always_comb begin
    st_d  = st_q;
    rnd_d = rnd_q;
    case (st_q)
      C_IDLE: begin
        if (ctl_i.start) begin
          st_d  = C_ROUND;
          rnd_d = '0;
        end
      end
      C_ROUND: begin
        rnd_d = rnd_q + RND_W'(1);
        if (rnd_q == RND_W'(ROUNDS - 1)) begin
          st_d = C_FOLD;
        end
      end
      C_FOLD: st_d = C_IDLE;
      default: st_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= C_IDLE;
      rnd_q <= '0;
    end else begin
      st_q  <= st_d;
      rnd_q <= rnd_d;
    end
  end

  // chaining words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q[0] <= IV_A;
      h_q[1] <= IV_B;
      h_q[2] <= IV_C;
      h_q[3] <= IV_D;
    end else if (ctl_i.reinit) begin
      h_q[0] <= IV_A;
      h_q[1] <= IV_B;
      h_q[2] <= IV_C;
      h_q[3] <= IV_D;
    end else if (st_q == C_FOLD) begin
      h_q[0] <= h_q[0] + a_q;
      h_q[1] <= h_q[1] + b_q;
      h_q[2] <= h_q[2] + c_q;
      h_q[3] <= h_q[3] + d_q;
    end
  end

  // working words
  always_ff @(posedge clk_i) begin
    if (st_q == C_IDLE && ctl_i.start) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
    end else if (st_q == C_ROUND) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= rot[63:32];
    end
  end

  assign done_o   = (st_q == C_FOLD);
  assign digest_o = {h_q[3], h_q[2], h_q[1], h_q[0]};

`ifndef SYNTHESIS
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> st_q == C_IDLE)
    else $error("md4 start while compressing");
  a_fold_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == C_ROUND && rnd_q == RND_W'(ROUNDS - 1)) |=> st_q == C_FOLD)
    else $error("md4 fold did not follow the last round");
`endif

endmodule
`default_nettype wire

// ===== src/ntph_out.sv =====
// ntph_out: result string serialiser, one character word per handshake
`default_nettype none
module ntph_out (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic         err_i,
  input  wire logic [127:0] digest_i,
  output logic              busy_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [6:0]        out_char_o,
  output logic              final_char_o,
  output logic              length_error_o
);
  import ntph_pkg::*;

  logic              busy_q, err_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [127:0]      dig_q;
  logic [CNT_W-1:0]  hex_pos;
  logic [7:0]        dbyte;
  logic [3:0]        nib;
  logic              last;
  logic              take;

  // digit selection: byte order low first, high nibble first
  assign hex_pos = cnt_q - CNT_W'(LEAD_CHARS);
  assign dbyte   = dig_q[8*hex_pos[4:1] +: 8];
  assign nib     = hex_pos[0] ? dbyte[3:0] : dbyte[7:4];
  assign last    = err_q || (cnt_q == CNT_W'(NUM_CHARS - 1));
  assign take    = busy_q && !out_stall_i;

  always_comb begin
    if (err_q) begin
      out_char_o = ERR_CHAR;
    end else if (cnt_q < CNT_W'(LEAD_CHARS)) begin
      out_char_o = lead_char(cnt_q[1:0]);
    end else begin
      out_char_o = hex_char(nib);
    end
  end

  assign out_valid_o    = busy_q;
  assign final_char_o   = last;
  assign length_error_o = err_q;
  assign busy_o         = busy_q;

  // character counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      err_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      err_q  <= err_i;
      cnt_q  <= '0;
    end else if (take) begin
      if (last) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // digest copy
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dig_q <= digest_i;
    end
  end

`ifndef SYNTHESIS
  a_start_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("result string started while one is still going out");
`endif

endmodule
`default_nettype wire

// ===== src/nt_password_hash_top.sv =====
// nt_password_hash_top: byte intake, block buffer, padding sequencer and result output
// An ordinary byte word is taken while idle; one that fills a 64-byte block adds
// one compression (the rounds in the shared round unit plus setup and fold).
// A final word within the bound adds padding and one or two compressions; then 36 characters
// (or one error word) go out at one per cycle when not stalled, while the next phrase is taken.
// Reset clears the chaining words, byte count and overflow flag; the block buffer needs no reset.
`default_nettype none
module nt_password_hash_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] pass_byte_i,
  input  wire logic       ends_phrase_i,
  input  wire logic       carries_no_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [6:0]      out_char_o,
  output logic            final_char_o,
  output logic            length_error_o
);
  import ntph_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PAD  = 7'b0000010,
    S_ZERO = 7'b0000100,
    S_LEN  = 7'b0001000,
    S_KICK = 7'b0010000,
    S_WAIT = 7'b0100000,
    S_EMIT = 7'b1000000
  } top_state_e;

  top_state_e st_q, st_d, ret_q, ret_d;
  logic [MSG_W-1:0] msg_q, msg_d;
  logic             ovf_q, ovf_d;
  logic [4:0]       ptr_q, ptr_d;
  logic [31:0]      buf_q [16];
  logic             in_take;
  logic             wr_en, len_wr;
  logic [4:0]       wr_half;
  logic [15:0]      wr_data;
  logic [5:0]       next_pos;
  ntph_core_ctl_t   core_ctl;
  logic [3:0]       w_idx;
  logic             core_done;
  logic [127:0]     digest;
  logic             out_start, out_busy;

  assign in_take    = in_valid_i && (st_q == S_IDLE);
  assign in_stall_o = (st_q != S_IDLE);
  assign next_pos   = 6'(msg_d);

  // sequencer
  always_comb begin
    st_d      = st_q;
    ret_d     = ret_q;
    msg_d     = msg_q;
    ovf_d     = ovf_q;
    ptr_d     = ptr_q;
    wr_en     = 1'b0;
    wr_half   = ptr_q;
    wr_data   = '0;
    len_wr    = 1'b0;
    core_ctl  = '0;
    out_start = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (in_take) begin
          if (!carries_no_byte_i) begin
            if (msg_q >= MSG_W'(MSG_MAX)) begin
              ovf_d = 1'b1;
            end else begin
              wr_en   = 1'b1;
              wr_half = 5'(6'(msg_q) >> 1);
              wr_data = {8'h00, pass_byte_i};
              msg_d   = msg_q + MSG_W'(2);
            end
          end
          ptr_d = next_pos[5:1];
          if (wr_en && next_pos == 6'd0) begin
            st_d  = S_KICK;
            ret_d = ends_phrase_i ? S_PAD : S_IDLE;
          end else if (ends_phrase_i) begin
            st_d = ovf_d ? S_EMIT : S_PAD;
          end
        end
      end
      S_PAD: begin
        wr_en   = 1'b1;
        wr_data = PAD_HALF;
        ptr_d   = ptr_q + 5'd1;
        if (ptr_q == HALF_LAST) begin
          st_d  = S_KICK;
          ret_d = S_ZERO;
        end else begin
          st_d = S_ZERO;
        end
      end
      S_ZERO: begin
        if (ptr_q == HALF_LEN) begin
          st_d = S_LEN;
        end else begin
          wr_en = 1'b1;
          ptr_d = ptr_q + 5'd1;
          if (ptr_q == HALF_LAST) begin
            st_d  = S_KICK;
            ret_d = S_ZERO;
          end
        end
      end
      S_LEN: begin
        len_wr = 1'b1;
        st_d   = S_KICK;
        ret_d  = S_EMIT;
      end
      S_KICK: begin
        core_ctl.start = 1'b1;
        st_d           = S_WAIT;
      end
      S_WAIT: begin
        if (core_done) begin
          st_d = ret_q;
        end
      end
      S_EMIT: begin
        if (!out_busy) begin
          out_start       = 1'b1;
          core_ctl.reinit = 1'b1;
          msg_d           = '0;
          ovf_d           = 1'b0;
          st_d            = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      ret_q <= S_IDLE;
      msg_q <= '0;
      ovf_q <= 1'b0;
      ptr_q <= '0;
    end else begin
      st_q  <= st_d;
      ret_q <= ret_d;
      msg_q <= msg_d;
      ovf_q <= ovf_d;
      ptr_q <= ptr_d;
    end
  end

  // block buffer, written a half word at a time; length words at the end
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_q[wr_half[4:1]][16*wr_half[0] +: 16] <= wr_data;
    end
    if (len_wr) begin
      buf_q[WORD_LEN_LO] <= 32'({msg_q, 3'b000});
      buf_q[WORD_LEN_HI] <= '0;
    end
  end

  ntph_md4_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (core_ctl),
    .w_idx_o  (w_idx),
    .w_i      (buf_q[w_idx]),
    .done_o   (core_done),
    .digest_o (digest)
  );

  ntph_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (out_start),
    .err_i          (ovf_q),
    .digest_i       (digest),
    .busy_o         (out_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .final_char_o   (final_char_o),
    .length_error_o (length_error_o)
  );

`ifndef SYNTHESIS
  a_msg_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_q <= MSG_W'(MSG_MAX))
    else $error("byte count beyond the passphrase bound");
  a_no_write_in_compress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_KICK || st_q == S_WAIT) |-> !wr_en && !len_wr)
    else $error("block buffer written during compression");
`endif

endmodule
`default_nettype wire

// ===== verif/nt_password_hash_top_tb.sv =====
// nt_password_hash_top_tb: self-checking testbench for the nt password hash block
module nt_password_hash_top_tb;
  import ntph_pkg::MAX_PASS_BYTES;

  // one character of the result string
  typedef struct packed {
    logic [6:0] ch;
    logic       fin;
    logic       err;
  } hash_char_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC,
    RX_HEAVY
  } rx_mode_e;

  // md4 message word order and rotate amounts per round group
  localparam logic [63:0]  G_ORDER   = 64'hFB73_EA62_D951_C840;
  localparam logic [63:0]  H_ORDER   = 64'hF7B3_D591_E6A2_C480;
  localparam logic [31:0]  F_SHIFTS  = 32'h13_0B_07_03;
  localparam logic [31:0]  G_SHIFTS  = 32'h0D_09_05_03;
  localparam logic [31:0]  H_SHIFTS  = 32'h0F_0B_09_03;
  localparam logic [127:0] HEX_STR   = "0123456789abcdef";
  localparam logic [31:0]  LEAD_STR  = "$3$$";
  localparam int unsigned  RAND_WORDS = 230;

  logic       clk_i;
  logic       rst_ni            = 1'b0;
  logic       in_valid_i        = 1'b0;
  logic [7:0] pass_byte_i       = 8'h00;
  logic       ends_phrase_i     = 1'b0;
  logic       carries_no_byte_i = 1'b0;
  logic       out_stall_i       = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [6:0] out_char_o;
  logic       final_char_o;
  logic       length_error_o;

  // predictor state
  logic [31:0] md_chain [4];
  logic [7:0]  md_block [64];
  int unsigned md_count;
  bit          md_overflow;
  hash_char_t  digest_q [$];

  // bookkeeping
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned phrases_done = 0;
  int unsigned phrases_too_long = 0;
  int unsigned chars_checked = 0;
  int unsigned burst_left = 0;

  rx_mode_e    rx_mode = RX_FREE;
  int unsigned rx_left = 0;
  logic [7:0]  rx_phase = 8'd0;
  hash_char_t  want_c;

  nt_password_hash_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .pass_byte_i       (pass_byte_i),
    .ends_phrase_i     (ends_phrase_i),
    .carries_no_byte_i (carries_no_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_char_o        (out_char_o),
    .final_char_o      (final_char_o),
    .length_error_o    (length_error_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard limit on run time
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  task automatic md4_restart();
    int unsigned i;
    md_chain[0] = 32'h6745_2301;
    md_chain[1] = 32'hefcd_ab89;
    md_chain[2] = 32'h98ba_dcfe;
    md_chain[3] = 32'h1032_5476;
    for (i = 0; i < 64; i++) md_block[i] = 8'h00;
    md_count    = 0;
    md_overflow = 1'b0;
  endtask

  task automatic md4_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, k, sum;
    int unsigned i, j, wi, s;
    for (i = 0; i < 16; i++) begin
      w[i] = {md_block[4*i+3], md_block[4*i+2], md_block[4*i+1], md_block[4*i]};
    end
    a = md_chain[0];
    b = md_chain[1];
    c = md_chain[2];
    d = md_chain[3];
    for (i = 0; i < 48; i++) begin
      j = i % 16;
      if (i < 16) begin
        f  = (b & c) | (~b & d);
        k  = 32'h0;
        wi = j;
        s  = F_SHIFTS[8*(j%4) +: 8];
      end else if (i < 32) begin
        f  = (b & c) | (b & d) | (c & d);
        k  = 32'h5a82_7999;
        wi = G_ORDER[4*j +: 4];
        s  = G_SHIFTS[8*(j%4) +: 8];
      end else begin
        f  = b ^ c ^ d;
        k  = 32'h6ed9_eba1;
        wi = H_ORDER[4*j +: 4];
        s  = H_SHIFTS[8*(j%4) +: 8];
      end
      sum = a + f + w[wi] + k;
      sum = (sum << s) | (sum >> (32 - s));
      a = d;
      d = c;
      c = b;
      b = sum;
    end
    md_chain[0] += a;
    md_chain[1] += b;
    md_chain[2] += c;
    md_chain[3] += d;
  endtask

  task automatic md4_take(input logic [7:0] v);
    md_block[md_count % 64] = v;
    md_count++;
    if (md_count % 64 == 0) md4_compress();
  endtask

  task automatic expect_char(input logic [7:0] ch, input logic fin, input logic err);
    hash_char_t x;
    x.ch  = ch[6:0];
    x.fin = fin;
    x.err = err;
    digest_q.push_back(x);
  endtask

  // model one accepted word; queues the characters it produces
  task automatic hash_word(input logic [7:0] b, input logic e, input logic nb);
    logic [63:0] len_bits;
    logic [7:0]  v;
    int unsigned i;
    if (!nb) begin
      if (md_count >= 2 * MAX_PASS_BYTES) begin
        md_overflow = 1'b1;
      end else begin
        md4_take(b);
        md4_take(8'h00);
      end
    end
    if (!e) return;
    phrases_done++;
    if (md_overflow) begin
      phrases_too_long++;
      expect_char(8'h00, 1'b1, 1'b1);
      md4_restart();
      return;
    end
    // pad, append bit length, finish
    len_bits = 64'(md_count) << 3;
    md4_take(8'h80);
    while (md_count % 64 != 56) md4_take(8'h00);
    for (i = 0; i < 8; i++) md4_take(len_bits[8*i +: 8]);
    for (i = 0; i < 4; i++) expect_char(LEAD_STR[8*(3-i) +: 8], 1'b0, 1'b0);
    for (i = 0; i < 16; i++) begin
      v = md_chain[i/4][8*(i%4) +: 8];
      expect_char(HEX_STR[8*(15-v[7:4]) +: 8], 1'b0, 1'b0);
      expect_char(HEX_STR[8*(15-v[3:0]) +: 8], i == 15, 1'b0);
    end
    md4_restart();
  endtask

  // ---------------------------------------------------------------- result side

  // receiver stall pattern, switching mode now and then
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 8'd1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:     out_stall_i <= 1'b0;
      RX_RANDOM:   out_stall_i <= ($urandom_range(0, 2) == 0);
      RX_PERIODIC: out_stall_i <= (rx_phase[2:0] < 3'd3);
      default:     out_stall_i <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // compare each accepted character with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      chars_checked++;
      if (digest_q.size() == 0) begin
        $error("unexpected word: out_char %h final_char %b length_error %b",
               out_char_o, final_char_o, length_error_o);
        errors++;
      end else begin
        want_c = digest_q.pop_front();
        if (out_char_o !== want_c.ch) begin
          $error("out_char: expected %h, got %h", want_c.ch, out_char_o);
          errors++;
        end
        if (final_char_o !== want_c.fin) begin
          $error("final_char: expected %b, got %b", want_c.fin, final_char_o);
          errors++;
        end
        if (length_error_o !== want_c.err) begin
          $error("length_error: expected %b, got %b", want_c.err, length_error_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- input side

  // send one word in bursts with random gaps; called at a rising edge
  task automatic send_word(input logic [7:0] b, input logic e, input logic nb);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i        <= 1'b1;
    pass_byte_i       <= b;
    ends_phrase_i     <= e;
    carries_no_byte_i <= nb;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    hash_word(b, e, nb);
    burst_left--;
    if (!nb || e) words_sent++;
  endtask

  // hold the input off until every expected character has come out
  task automatic wait_for_digests();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- tests

  // empty phrase, ignored words, single bytes and mixed no-byte words
  task automatic test_short_phrases();
    send_word(8'h3C, 1'b1, 1'b1);
    send_word(8'hA5, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word("a", 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1);
    send_word("b", 1'b0, 1'b0);
    send_word("c", 1'b1, 1'b0);
    send_word(8'h80, 1'b0, 1'b0);
    send_word(8'h7F, 1'b1, 1'b1);
    send_word(8'h55, 1'b0, 1'b0);
    send_word(8'hAA, 1'b0, 1'b0);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'hC3, 1'b1, 1'b1);
    wait_for_digests();
  endtask

  // exactly the bound, ending on a byte
  task automatic test_longest_phrase();
    int unsigned n;
    for (n = 0; n < MAX_PASS_BYTES; n++) begin
      send_word(8'($urandom_range(0, 255)), n == MAX_PASS_BYTES - 1, 1'b0);
    end
    wait_for_digests();
  endtask

  // two bytes past the bound with a no-byte word inside, then a short phrase
  task automatic test_over_length();
    int unsigned n;
    for (n = 0; n < MAX_PASS_BYTES + 2; n++) begin
      if (n == MAX_PASS_BYTES) send_word(8'h00, 1'b0, 1'b1);
      send_word(8'($urandom_range(0, 255)), n == MAX_PASS_BYTES + 1, 1'b0);
    end
    send_word("x", 1'b1, 1'b0);
    wait_for_digests();
  endtask

  // random phrases, lengths clustered round the block boundary, some noise
  task automatic test_random_phrases();
    int unsigned len, pick, n, first_word;
    bit          end_with_byte;
    first_word = words_sent;
    while (words_sent - first_word < RAND_WORDS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(0, 40);
      else if (pick < 8) len = $urandom_range(26, 34);
      else len = $urandom_range(41, 130);
      end_with_byte = (len != 0) && ($urandom_range(0, 1) == 1);
      for (n = 0; n < len; n++) begin
        if ($urandom_range(0, 11) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        send_word(8'($urandom_range(0, 255)), end_with_byte && (n == len - 1), 1'b0);
      end
      if (!end_with_byte) send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      if ($urandom_range(0, 5) == 0) wait_for_digests();
    end
    wait_for_digests();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    md4_restart();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_phrases();
    test_longest_phrase();
    test_over_length();
    test_random_phrases();

    // let any stray output show up
    repeat (300) @(posedge clk_i);

    $display("run covered %0d phrases (%0d over length), %0d words in, %0d characters out",
             phrases_done, phrases_too_long, words_sent, chars_checked);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
